// ----- sv/trst_pkg.sv -----
package trst_pkg;
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned PORT_W = 16;
   localparam int unsigned NUM_W  = 32;
   localparam int unsigned REL_W  = 33;
   localparam int unsigned FLAG_SYN_BIT = 1;
   localparam int unsigned FLAG_ACK_BIT = 4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2*ADDR_W-1:0] addrs;
      logic [2*PORT_W-1:0] ports;
   } tuple_type;

   // lookup token travelling down the chain
   typedef struct packed {
      logic                valid;
      tuple_type           fwd;
      tuple_type           rev;
      logic                fwd_hit;
      logic                rev_hit;
      logic                free_hit;
      logic [NUM_W-1:0]    f_cisn;
      logic [NUM_W-1:0]    f_sisn;
      logic                f_cset;
      logic                r_cset;
      logic [NUM_W-1:0]    r_cisn;
      logic [NUM_W-1:0]    r_sisn;
      logic                r_sset;
   } probe_type;

   // update command travelling down the chain
   typedef struct packed {
      logic             valid;
      logic             alloc;   // claim first free cell
      logic             use_rev; // not read by the cells; key selects the tuple
      tuple_type        key;
      tuple_type        fwd;
      logic             wr_cisn;
      logic             wr_sisn;
      logic [NUM_W-1:0] value;
   } upd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_UPDATE
   } state_type;
endpackage

// ----- sv/trst_cell.sv -----
module trst_cell (
   input  logic               clock,
   input  logic               reset,
   input  trst_pkg::probe_type probe_i,
   output trst_pkg::probe_type probe_o,
   input  trst_pkg::upd_type   upd_i,
   output trst_pkg::upd_type   upd_o
);
   import trst_pkg::*;

   logic valid_ff, cset_ff, sset_ff;
   tuple_type tup_ff;
   logic [NUM_W-1:0] cisn_ff, sisn_ff;
   probe_type probe_in, probe_ff;
   upd_type upd_in, upd_ff;
   logic fm, rm, mine;

   assign fm = valid_ff && tup_ff == probe_i.fwd;
   assign rm = valid_ff && tup_ff == probe_i.rev;

   always_comb begin
      probe_in = probe_i;
      if (probe_i.valid) begin
         if (fm && !probe_i.fwd_hit) begin
            probe_in.fwd_hit = 1'b1;
            probe_in.f_cisn = cisn_ff;
            probe_in.f_sisn = sisn_ff;
            probe_in.f_cset = cset_ff;
         end
         if (rm && !probe_i.rev_hit) begin
            probe_in.rev_hit = 1'b1;
            probe_in.r_cisn = cisn_ff;
            probe_in.r_sisn = sisn_ff;
            probe_in.r_cset = cset_ff;
            probe_in.r_sset = sset_ff;
         end
         if (!valid_ff) probe_in.free_hit = 1'b1;
      end
   end

   always_comb begin
      upd_in = upd_i;
      mine = 1'b0;
      if (upd_i.valid) begin
         if (upd_i.alloc) begin
            mine = !valid_ff;
         end else begin
            mine = valid_ff && tup_ff == upd_i.key;
         end
         if (mine) upd_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cset_ff  <= 1'b0;
         sset_ff  <= 1'b0;
         probe_ff <= '0;
         upd_ff   <= '0;
      end else begin
         probe_ff <= probe_in;
         upd_ff   <= upd_in;
         if (mine) begin
            if (upd_i.alloc) begin
               valid_ff <= 1'b1;
               tup_ff   <= upd_i.fwd;
            end
            if (upd_i.alloc || upd_i.wr_cisn) begin
               cisn_ff <= upd_i.value;
               cset_ff <= 1'b1;
            end
            if (upd_i.wr_sisn) begin
               sisn_ff <= upd_i.value;
               sset_ff <= 1'b1;
            end else if (upd_i.alloc) begin
               sisn_ff <= '0;
               sset_ff <= 1'b0;
            end
         end
      end
   end

   assign probe_o = probe_ff;
   assign upd_o   = upd_ff;
endmodule

// ----- sv/tcp_relative_sequence_tracker_unit.sv -----
// the probe walks the cell chain one cell a cycle and rsp_valid is
// registered from the chain end; the update walk down the chain follows,
// and busy stays high until it is through
// a new request is taken only while busy is low
// reset: synchronous, clears every flow entry at once
// the receiver cannot stall: rsp_valid is a one-cycle strobe
module tcp_relative_sequence_tracker_unit #(
   parameter int unsigned FLOW_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [trst_pkg::ADDR_W-1:0]   req_src_addr,
   input  logic [trst_pkg::ADDR_W-1:0]   req_dst_addr,
   input  logic [trst_pkg::PORT_W-1:0]   req_src_port,
   input  logic [trst_pkg::PORT_W-1:0]   req_dst_port,
   input  logic [trst_pkg::NUM_W-1:0]    req_seq_num,
   input  logic [trst_pkg::NUM_W-1:0]    req_ack_num,
   input  logic [7:0]                    req_tcp_flags,
   output logic                          rsp_valid,
   output logic signed [trst_pkg::REL_W-1:0] rsp_rel_seq,
   output logic signed [trst_pkg::REL_W-1:0] rsp_rel_ack,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_to_client
);
   import trst_pkg::*;

   localparam int unsigned CNT_W = $clog2(FLOW_ENTRIES + 1);

   probe_type probe_chain [FLOW_ENTRIES+1];
   upd_type   upd_chain   [FLOW_ENTRIES+1];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   tuple_type fwd_ff, rev_ff;
   logic [NUM_W-1:0] seq_ff, ack_ff;
   logic syn_ff, ackf_ff;
   probe_type res;
   upd_type upd_cmd;
   logic fire, last;
   logic [REL_W-1:0] rs, ra;
   logic [1:0] st;
   logic tc;

   genvar g;
   generate
      for (g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
         trst_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .probe_i (probe_chain[g]),
            .probe_o (probe_chain[g+1]),
            .upd_i   (upd_chain[g]),
            .upd_o   (upd_chain[g+1])
         );
      end
   endgenerate

   assign res  = probe_chain[FLOW_ENTRIES];
   assign last = cnt_ff == CNT_W'(FLOW_ENTRIES);
   assign busy = state_ff != S_IDLE;

   always_comb begin
      probe_chain[0] = '0;
      probe_chain[0].valid = start && !busy;
      probe_chain[0].fwd = {{req_src_addr, req_dst_addr}, {req_src_port, req_dst_port}};
      probe_chain[0].rev = {{req_dst_addr, req_src_addr}, {req_dst_port, req_src_port}};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_PROBE;
            cnt_in = '0;
         end
         S_PROBE: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = S_UPDATE;
               cnt_in = '0;
            end
         end
         S_UPDATE: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      if (start && !busy) begin
         fwd_ff  <= probe_chain[0].fwd;
         rev_ff  <= probe_chain[0].rev;
         seq_ff  <= req_seq_num;
         ack_ff  <= req_ack_num;
         syn_ff  <= req_tcp_flags[FLAG_SYN_BIT];
         ackf_ff <= req_tcp_flags[FLAG_ACK_BIT];
      end
   end

   // decision at the chain end
   always_comb begin
      logic f, r, alloc;
      logic [NUM_W-1:0] cisn, sisn;
      fire = res.valid;
      f = res.fwd_hit;
      r = res.rev_hit;
      alloc = 1'b0;
      cisn = res.f_cisn;
      sisn = res.f_sisn;
      rs = '0; ra = '0; st = ST_NONE; tc = 1'b0;
      upd_cmd = '0;
      upd_cmd.fwd = fwd_ff;
      upd_cmd.value = seq_ff;
      upd_cmd.key = fwd_ff;
      if (!f && !r) begin
         if (!res.free_hit) begin
            st = ST_FULL;
         end else begin
            alloc = 1'b1;
            f = 1'b1;
            r = fwd_ff == rev_ff;
         end
      end
      if (st != ST_FULL) begin
         upd_cmd.valid = fire && alloc;
         upd_cmd.alloc = alloc;
         if (syn_ff && !ackf_ff) begin
            if (f) begin
               upd_cmd.valid = fire;
               upd_cmd.wr_cisn = !alloc;
               rs = '0; ra = '1; st = ST_OK;
            end
         end else if (syn_ff) begin
            if (r) begin
               upd_cmd.valid = fire;
               upd_cmd.wr_sisn = 1'b1;
               upd_cmd.key = rev_ff;
               rs = '0; ra = REL_W'(1); st = ST_OK; tc = 1'b1;
            end
         end else if (f) begin
            if (alloc) begin
               cisn = seq_ff;
               sisn = '0;
            end else begin
               sisn = res.f_sisn;
               if (!res.f_cset) begin
                  cisn = seq_ff;
                  upd_cmd.valid = fire;
                  upd_cmd.wr_cisn = 1'b1;
               end
            end
            rs = {1'b0, seq_ff - cisn};
            ra = {1'b0, ack_ff - sisn};
            st = ST_OK;
         end else begin
            sisn = res.r_sisn;
            if (!res.r_sset) begin
               sisn = seq_ff;
               upd_cmd.valid = fire;
               upd_cmd.wr_sisn = 1'b1;
               upd_cmd.key = rev_ff;
            end
            rs = {1'b0, seq_ff - sisn};
            ra = {1'b0, ack_ff - res.r_cisn};
            st = ST_OK; tc = 1'b1;
         end
      end
   end

   always_comb begin
      upd_chain[0] = '0;
      if (upd_cmd.valid) upd_chain[0] = upd_cmd;
   end

   always_ff @(posedge clock) begin
      rsp_rel_seq   <= rs;
      rsp_rel_ack   <= ra;
      rsp_status    <= st;
      rsp_to_client <= tc;
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= fire;
   end
endmodule

// ----- sim/tb_tcp_relative_sequence_tracker_unit.sv -----
module tb_tcp_relative_sequence_tracker_unit;
   import trst_pkg::*;

   localparam int unsigned FLOWS = 64;
   localparam int unsigned LATENCY = 2 * FLOWS + 2;
   localparam longint unsigned CYCLE_LIMIT = 64'd1900 * (LATENCY + 80) * 4 + 100000;

   typedef struct {
      logic signed [REL_W-1:0] rel_seq;
      logic signed [REL_W-1:0] rel_ack;
      logic [1:0]              status;
      logic                    to_client;
   } seg_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [ADDR_W-1:0]        req_src_addr = '0;
   logic [ADDR_W-1:0]        req_dst_addr = '0;
   logic [PORT_W-1:0]        req_src_port = '0;
   logic [PORT_W-1:0]        req_dst_port = '0;
   logic [NUM_W-1:0]         req_seq_num = '0;
   logic [NUM_W-1:0]         req_ack_num = '0;
   logic [7:0]               req_tcp_flags = '0;
   logic                     rsp_valid;
   logic signed [REL_W-1:0]  rsp_rel_seq;
   logic signed [REL_W-1:0]  rsp_rel_ack;
   logic [1:0]               rsp_status;
   logic                     rsp_to_client;

   // flow table shadow
   logic                  flow_used [FLOWS];
   logic [2*ADDR_W-1:0]   flow_addrs [FLOWS];
   logic [2*PORT_W-1:0]   flow_ports [FLOWS];
   logic [NUM_W-1:0]      flow_cisn [FLOWS];
   logic [NUM_W-1:0]      flow_sisn [FLOWS];
   logic                  flow_cset [FLOWS];
   logic                  flow_sset [FLOWS];

   seg_result_type pending_results[$];
   int unsigned error_count = 0;
   longint unsigned cycle_count = 0;

   // known flows for random traffic
   logic [ADDR_W-1:0] pool_sa [16];
   logic [ADDR_W-1:0] pool_da [16];
   logic [PORT_W-1:0] pool_sp [16];
   logic [PORT_W-1:0] pool_dp [16];
   logic [NUM_W-1:0]  pool_seq [16];

   tcp_relative_sequence_tracker_unit #(.FLOW_ENTRIES(FLOWS)) DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int find_flow(logic [2*ADDR_W-1:0] a, logic [2*PORT_W-1:0] p);
      for (int i = 0; i < FLOWS; i++)
         if (flow_used[i] && flow_addrs[i] == a && flow_ports[i] == p) return i;
      return -1;
   endfunction

   function automatic seg_result_type track_segment(logic [ADDR_W-1:0] sa,
         logic [ADDR_W-1:0] da, logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp,
         logic [NUM_W-1:0] seq, logic [NUM_W-1:0] ack, logic [7:0] flags);
      seg_result_type res;
      logic [2*ADDR_W-1:0] fa, ra;
      logic [2*PORT_W-1:0] fp, rp;
      logic syn, ackf;
      int f, r, n;
      logic [NUM_W-1:0] d1, d2;
      fa = {sa, da};
      ra = {da, sa};
      fp = {sp, dp};
      rp = {dp, sp};
      syn = flags[FLAG_SYN_BIT];
      ackf = flags[FLAG_ACK_BIT];
      res = '{rel_seq: '0, rel_ack: '0, status: ST_NONE, to_client: 1'b0};
      f = find_flow(fa, fp);
      r = find_flow(ra, rp);
      if (f < 0 && r < 0) begin
         n = -1;
         for (int i = FLOWS - 1; i >= 0; i--)
            if (!flow_used[i]) n = i;
         if (n < 0) begin
            res.status = ST_FULL;
            return res;
         end
         flow_used[n] = 1'b1;
         flow_addrs[n] = fa;
         flow_ports[n] = fp;
         flow_cisn[n] = seq;
         flow_cset[n] = 1'b1;
         flow_sisn[n] = '0;
         flow_sset[n] = 1'b0;
         f = n;
         if (fa == ra && fp == rp) r = n;
      end
      if (syn && !ackf) begin
         if (f >= 0) begin
            flow_cisn[f] = seq;
            flow_cset[f] = 1'b1;
            res = '{rel_seq: '0, rel_ack: '1, status: ST_OK, to_client: 1'b0};
         end
      end else if (syn) begin
         if (r >= 0) begin
            flow_sisn[r] = seq;
            flow_sset[r] = 1'b1;
            res = '{rel_seq: '0, rel_ack: REL_W'(1), status: ST_OK, to_client: 1'b1};
         end
      end else if (f >= 0) begin
         if (!flow_cset[f]) begin
            flow_cisn[f] = seq;
            flow_cset[f] = 1'b1;
         end
         d1 = seq - flow_cisn[f];
         d2 = ack - flow_sisn[f];
         res = '{rel_seq: {1'b0, d1}, rel_ack: {1'b0, d2}, status: ST_OK, to_client: 1'b0};
      end else if (r >= 0) begin
         if (!flow_sset[r]) begin
            flow_sisn[r] = seq;
            flow_sset[r] = 1'b1;
         end
         d1 = seq - flow_sisn[r];
         d2 = ack - flow_cisn[r];
         res = '{rel_seq: {1'b0, d1}, rel_ack: {1'b0, d2}, status: ST_OK, to_client: 1'b1};
      end
      return res;
   endfunction

   task automatic idle_gap();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 40) k = 0;
      else if (k < 92) k = $urandom_range(1, 4);
      else k = $urandom_range(20, 200);
      repeat (k) @(negedge clock);
   endtask

   task automatic send_segment(logic [ADDR_W-1:0] sa, logic [ADDR_W-1:0] da,
         logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp, logic [NUM_W-1:0] seq,
         logic [NUM_W-1:0] ack, logic [7:0] flags, bit with_gap = 1);
      if (with_gap) idle_gap();
      req_src_addr = sa;
      req_dst_addr = da;
      req_src_port = sp;
      req_dst_port = dp;
      req_seq_num = seq;
      req_ack_num = ack;
      req_tcp_flags = flags;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_results.push_back(track_segment(sa, da, sp, dp, seq, ack, flags));
      @(negedge clock);
      start = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: actual %0d %0d %0d %0d", $time,
               rsp_rel_seq, rsp_rel_ack, rsp_status, rsp_to_client);
            error_count++;
         end else begin
            seg_result_type e;
            e = pending_results.pop_front();
            if (rsp_rel_seq !== e.rel_seq) begin
               $display("%0t rel_seq expected %0d actual %0d", $time, e.rel_seq, rsp_rel_seq);
               error_count++;
            end
            if (rsp_rel_ack !== e.rel_ack) begin
               $display("%0t rel_ack expected %0d actual %0d", $time, e.rel_ack, rsp_rel_ack);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t status expected %0d actual %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_to_client !== e.to_client) begin
               $display("%0t to_client expected %0d actual %0d", $time, e.to_client,
                  rsp_to_client);
               error_count++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // handshake, self-reverse tuple, field extremes, syn without entry, large difference
   task automatic test_directed();
      logic [7:0] syn_f, synack_f, ack_f;
      syn_f = 8'h02;
      synack_f = 8'h12;
      ack_f = 8'h10;
      send_segment(32'h0a000001, 32'h0a000002, 16'd1000, 16'd80, 32'd100, 32'd0, syn_f);
      send_segment(32'h0a000002, 32'h0a000001, 16'd80, 16'd1000, 32'd5000, 32'd101, synack_f);
      send_segment(32'h0a000001, 32'h0a000002, 16'd1000, 16'd80, 32'd101, 32'd5001, ack_f);
      send_segment(32'h0a000002, 32'h0a000001, 16'd80, 16'd1000, 32'd5001, 32'd101, ack_f);
      // synack for unknown flow
      send_segment(32'hffffffff, 32'h0, 16'hffff, 16'h0, 32'hffffffff, 32'hffffffff, 8'hff);
      send_segment(32'h0, 32'hffffffff, 16'h0, 16'hffff, 32'h0, 32'h0, 8'hed);
      send_segment(32'hffffffff, 32'h0, 16'hffff, 16'h0, 32'h0, 32'h1, 8'h00);
      // self-reverse
      send_segment(32'h12345678, 32'h12345678, 16'd7, 16'd7, 32'd10, 32'd20, synack_f);
      send_segment(32'h12345678, 32'h12345678, 16'd7, 16'd7, 32'd3, 32'd30, ack_f);
      send_segment(32'h12345678, 32'h12345678, 16'd7, 16'd7, 32'd1, 32'd1, syn_f);
      // modular difference near the top of the range
      send_segment(32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 32'h0, 32'h0, 8'h00);
      send_segment(32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 32'hfffffff0, 32'h7, 8'h00);
      send_segment(32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555, 32'h9, 32'h0, 8'h01);
      drain();
   endtask

   task automatic test_random_flows(int unsigned count);
      int unsigned p;
      logic [7:0] flg;
      for (int i = 0; i < 16; i++) begin
         pool_sa[i] = $urandom;
         pool_da[i] = $urandom;
         pool_sp[i] = PORT_W'($urandom);
         pool_dp[i] = PORT_W'($urandom);
         pool_seq[i] = $urandom;
      end
      for (int unsigned n = 0; n < count; n++) begin
         p = $urandom_range(0, 15);
         flg = 8'($urandom);
         if ($urandom_range(0, 9) < 2) begin
            send_segment($urandom, $urandom, PORT_W'($urandom), PORT_W'($urandom),
               $urandom, $urandom, flg);
         end else if ($urandom_range(0, 1)) begin
            send_segment(pool_sa[p], pool_da[p], pool_sp[p], pool_dp[p],
               pool_seq[p] + $urandom_range(0, 3000), $urandom, flg);
         end else begin
            send_segment(pool_da[p], pool_sa[p], pool_dp[p], pool_sp[p],
               $urandom, pool_seq[p] + $urandom_range(0, 3000), flg);
         end
      end
      drain();
   endtask

   // exhaust the table, then go on with random traffic on a fresh pool of flows
   task automatic test_table_full();
      for (int i = 0; i < FLOWS + 4; i++)
         send_segment($urandom, $urandom, PORT_W'($urandom), PORT_W'($urandom),
            $urandom, $urandom, 8'($urandom), i % 3 == 0);
      drain();
      repeat (LATENCY) @(negedge clock);
      test_random_flows(1700);
   endtask

   initial begin
      for (int i = 0; i < FLOWS; i++) begin
         flow_used[i] = 1'b0;
         flow_addrs[i] = '0;
         flow_ports[i] = '0;
         flow_cisn[i] = '0;
         flow_sisn[i] = '0;
         flow_cset[i] = 1'b0;
         flow_sset[i] = 1'b0;
      end
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_flows(120);
      test_table_full();
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
sv/trst_pkg.sv
sv/trst_cell.sv
sv/tcp_relative_sequence_tracker_unit.sv
sim/tb_tcp_relative_sequence_tracker_unit.sv
